// ===== design/ps2d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2d_pkg
// Shared types, codes and lookup tables of the scancode-to-text decoder.
// ----------------------------------------------------------------------------
package ps2d_pkg;

   localparam int unsigned SCAN_W  = 8;
   localparam int unsigned CHAR_W  = 7;
   localparam int unsigned CSET_W  = 2;
   localparam int unsigned PADDR_W = 3;
   localparam int unsigned PDATA_W = 32;

   // scancode set selection
   localparam logic [CSET_W-1:0] CSET_ONE = 2'd1;
   localparam logic [CSET_W-1:0] CSET_TWO = 2'd2;

   // register index of code_set
   localparam logic REG_CODE_SET = 1'b0;

   localparam logic [SCAN_W-1:0] PREFIX_RELEASE = 8'hF0;
   localparam logic [SCAN_W-1:0] KEY_LSHIFT     = 8'h2A;
   localparam logic [SCAN_W-1:0] KEY_RSHIFT     = 8'h36;
   localparam logic [SCAN_W-1:0] KEY_CTRL       = 8'h1D;
   localparam logic [SCAN_W-1:0] KEY_ALT        = 8'h38;
   localparam logic [SCAN_W-1:0] KEY_CAPS       = 8'h3A;

   typedef struct packed {
      logic release_pending;
      logic shift;
      logic ctrl;
      logic alt;
      logic caps;
   } mod_state_type;

   // set 2 to set 1 translation
   function automatic logic [SCAN_W-1:0] set2_lookup(input logic [6:0] idx);
      logic [SCAN_W-1:0] r;
      r = 8'h00;
      case (idx)
         7'h01: r = 8'h3B; 7'h03: r = 8'h3F; 7'h04: r = 8'h3D; 7'h05: r = 8'h3B;
         7'h06: r = 8'h3C; 7'h07: r = 8'h58; 7'h09: r = 8'h44; 7'h0A: r = 8'h42;
         7'h0B: r = 8'h40; 7'h0C: r = 8'h3E; 7'h0D: r = 8'h0F; 7'h0E: r = 8'h29;
         7'h11: r = 8'h38; 7'h12: r = 8'h2A; 7'h14: r = 8'h1D; 7'h15: r = 8'h10;
         7'h16: r = 8'h02; 7'h1A: r = 8'h2C; 7'h1B: r = 8'h1F; 7'h1C: r = 8'h1E;
         7'h1D: r = 8'h11; 7'h1E: r = 8'h03; 7'h21: r = 8'h2E; 7'h22: r = 8'h2D;
         7'h23: r = 8'h20; 7'h24: r = 8'h12; 7'h25: r = 8'h05; 7'h26: r = 8'h04;
         7'h29: r = 8'h39; 7'h2A: r = 8'h2F; 7'h2B: r = 8'h21; 7'h2C: r = 8'h14;
         7'h2D: r = 8'h13; 7'h2E: r = 8'h06; 7'h31: r = 8'h31; 7'h32: r = 8'h30;
         7'h33: r = 8'h23; 7'h34: r = 8'h22; 7'h35: r = 8'h15; 7'h36: r = 8'h07;
         7'h3A: r = 8'h32; 7'h3B: r = 8'h24; 7'h3C: r = 8'h16; 7'h3D: r = 8'h08;
         7'h3E: r = 8'h09; 7'h41: r = 8'h33; 7'h42: r = 8'h25; 7'h43: r = 8'h17;
         7'h44: r = 8'h18; 7'h45: r = 8'h0B; 7'h46: r = 8'h0A; 7'h49: r = 8'h34;
         7'h4A: r = 8'h35; 7'h4B: r = 8'h26; 7'h4C: r = 8'h27; 7'h4D: r = 8'h19;
         7'h4E: r = 8'h0C; 7'h52: r = 8'h28; 7'h54: r = 8'h1A; 7'h55: r = 8'h0D;
         7'h58: r = 8'h3A; 7'h59: r = 8'h36; 7'h5A: r = 8'h1C; 7'h5B: r = 8'h1B;
         7'h5D: r = 8'h2B; 7'h66: r = 8'h0E; 7'h69: r = 8'h4F; 7'h6B: r = 8'h4B;
         7'h6C: r = 8'h47; 7'h70: r = 8'h52; 7'h71: r = 8'h53; 7'h72: r = 8'h50;
         7'h73: r = 8'h4C; 7'h74: r = 8'h4E; 7'h75: r = 8'h48; 7'h76: r = 8'h01;
         7'h77: r = 8'h45; 7'h78: r = 8'h57; 7'h79: r = 8'h4E; 7'h7A: r = 8'h4D;
         7'h7B: r = 8'h4A; 7'h7C: r = 8'h37; 7'h7D: r = 8'h49; 7'h7E: r = 8'h46;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // US layout, set 1 key code to character; upper selects the shifted column
   function automatic logic [CHAR_W-1:0] char_lookup(input logic [6:0] key,
                                                      input logic upper);
      logic [CHAR_W-1:0] lo;
      logic [CHAR_W-1:0] hi;
      lo = 7'h00;
      hi = 7'h00;
      case (key)
         7'h02: begin lo = 7'h31; hi = 7'h21; end
         7'h03: begin lo = 7'h32; hi = 7'h40; end
         7'h04: begin lo = 7'h33; hi = 7'h23; end
         7'h05: begin lo = 7'h34; hi = 7'h24; end
         7'h06: begin lo = 7'h35; hi = 7'h25; end
         7'h07: begin lo = 7'h36; hi = 7'h5E; end
         7'h08: begin lo = 7'h37; hi = 7'h26; end
         7'h09: begin lo = 7'h38; hi = 7'h2A; end
         7'h0A: begin lo = 7'h39; hi = 7'h28; end
         7'h0B: begin lo = 7'h30; hi = 7'h29; end
         7'h0C: begin lo = 7'h2D; hi = 7'h5F; end
         7'h0D: begin lo = 7'h3D; hi = 7'h2B; end
         7'h0E: begin lo = 7'h08; hi = 7'h08; end
         7'h0F: begin lo = 7'h09; hi = 7'h09; end
         7'h10: begin lo = 7'h71; hi = 7'h51; end
         7'h11: begin lo = 7'h77; hi = 7'h57; end
         7'h12: begin lo = 7'h65; hi = 7'h45; end
         7'h13: begin lo = 7'h72; hi = 7'h52; end
         7'h14: begin lo = 7'h74; hi = 7'h54; end
         7'h15: begin lo = 7'h79; hi = 7'h59; end
         7'h16: begin lo = 7'h75; hi = 7'h55; end
         7'h17: begin lo = 7'h69; hi = 7'h49; end
         7'h18: begin lo = 7'h6F; hi = 7'h4F; end
         7'h19: begin lo = 7'h70; hi = 7'h50; end
         7'h1A: begin lo = 7'h5B; hi = 7'h7B; end
         7'h1B: begin lo = 7'h5D; hi = 7'h7D; end
         7'h1C: begin lo = 7'h0A; hi = 7'h0A; end
         7'h1E: begin lo = 7'h61; hi = 7'h41; end
         7'h1F: begin lo = 7'h73; hi = 7'h53; end
         7'h20: begin lo = 7'h64; hi = 7'h44; end
         7'h21: begin lo = 7'h66; hi = 7'h46; end
         7'h22: begin lo = 7'h67; hi = 7'h47; end
         7'h23: begin lo = 7'h68; hi = 7'h48; end
         7'h24: begin lo = 7'h6A; hi = 7'h4A; end
         7'h25: begin lo = 7'h6B; hi = 7'h4B; end
         7'h26: begin lo = 7'h6C; hi = 7'h4C; end
         7'h27: begin lo = 7'h3B; hi = 7'h3A; end
         7'h28: begin lo = 7'h27; hi = 7'h22; end
         7'h29: begin lo = 7'h60; hi = 7'h7E; end
         7'h2B: begin lo = 7'h5C; hi = 7'h7C; end
         7'h2C: begin lo = 7'h7A; hi = 7'h5A; end
         7'h2D: begin lo = 7'h78; hi = 7'h58; end
         7'h2E: begin lo = 7'h63; hi = 7'h43; end
         7'h2F: begin lo = 7'h76; hi = 7'h56; end
         7'h30: begin lo = 7'h62; hi = 7'h42; end
         7'h31: begin lo = 7'h6E; hi = 7'h4E; end
         7'h32: begin lo = 7'h6D; hi = 7'h4D; end
         7'h33: begin lo = 7'h2C; hi = 7'h3C; end
         7'h34: begin lo = 7'h2E; hi = 7'h3E; end
         7'h35: begin lo = 7'h2F; hi = 7'h3F; end
         7'h39: begin lo = 7'h20; hi = 7'h20; end
         default: begin lo = 7'h00; hi = 7'h00; end
      endcase
      return upper ? hi : lo;
   endfunction

endpackage

// ===== design/ps2d_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2d_req_if / ps2d_rsp_if
// Valid/ready channels carrying scancode words in and character words out.
// ----------------------------------------------------------------------------
interface ps2d_req_if;
   logic                          valid;
   logic                          ready;
   logic [ps2d_pkg::SCAN_W-1:0]   scan_byte;

   modport source (output valid, output scan_byte, input ready);
   modport sink   (input valid, input scan_byte, output ready);
endinterface

interface ps2d_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ps2d_pkg::CHAR_W-1:0]   char_byte;
   logic                          shift_down;
   logic                          ctrl_down;
   logic                          alt_down;
   logic                          caps_lock;

   modport source (output valid, output char_byte, output shift_down, output ctrl_down,
                   output alt_down, output caps_lock, input ready);
   modport sink   (input valid, input char_byte, input shift_down, input ctrl_down,
                   input alt_down, input caps_lock, output ready);
endinterface

// ===== design/ps2d_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2d_decode
// Single-pass decode of one scancode word: next modifier state and character.
// ----------------------------------------------------------------------------
module ps2d_decode (
   input  logic [ps2d_pkg::SCAN_W-1:0] scan_byte,
   input  logic [ps2d_pkg::CSET_W-1:0] code_set,
   input  ps2d_pkg::mod_state_type     cur_state,
   output ps2d_pkg::mod_state_type     nxt_state,
   output logic                        emit,
   output logic [ps2d_pkg::CHAR_W-1:0] char_byte
);

   logic [ps2d_pkg::SCAN_W-1:0] key;
   logic                        rel;
   logic                        swallow;
   logic [ps2d_pkg::CHAR_W-1:0] ch;

   always_comb begin
      nxt_state = cur_state;
      key       = scan_byte;
      rel       = 1'b0;
      swallow   = 1'b0;
      emit      = 1'b0;

      unique case (code_set)
         ps2d_pkg::CSET_TWO: begin
            if (scan_byte == ps2d_pkg::PREFIX_RELEASE) begin
               nxt_state.release_pending = 1'b1;
               swallow = 1'b1;
            end else if (cur_state.release_pending) begin
               // prefixed code: indexes of 0x80 and up read as no key
               rel = 1'b1;
               nxt_state.release_pending = 1'b0;
               key = scan_byte[7] ? '0 : ps2d_pkg::set2_lookup(scan_byte[6:0]);
            end else begin
               rel = scan_byte[7];
               key = ps2d_pkg::set2_lookup(scan_byte[6:0]);
            end
         end
         ps2d_pkg::CSET_ONE: begin
            rel = scan_byte[7];
            key = {1'b0, scan_byte[6:0]};
         end
         default: begin
            key = scan_byte;
         end
      endcase

      ch = ps2d_pkg::char_lookup(key[6:0], cur_state.shift ^ cur_state.caps);

      if (!swallow) begin
         if (key == ps2d_pkg::KEY_LSHIFT || key == ps2d_pkg::KEY_RSHIFT) begin
            nxt_state.shift = !rel;
         end else if (key == ps2d_pkg::KEY_CTRL) begin
            nxt_state.ctrl = !rel;
         end else if (key == ps2d_pkg::KEY_ALT) begin
            nxt_state.alt = !rel;
         end else if (key == ps2d_pkg::KEY_CAPS && !rel) begin
            nxt_state.caps = !cur_state.caps;
         end else if (!rel && !key[7] && ch != '0) begin
            emit = 1'b1;
         end
      end
   end

   assign char_byte = ch;

endmodule

// ===== design/ps2_scancode_to_text_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_scancode_to_text_decoder_core
// PS/2 keyboard scancode to ASCII text decoder with modifier tracking.
// ----------------------------------------------------------------------------
// Takes one keyboard scancode word per cycle on req when ready and returns at
// most one character word on rsp, carrying the ASCII code and the shift,
// ctrl, alt and caps-lock state after that scancode. code_set (byte address
// 0) picks the scancode set: 2 handles the 0xF0 release prefix and translates
// to set 1, 1 treats bit 7 as release, 0 and 3 pass the raw byte as the key
// code. rsp is registered; throughput is one word per cycle unless rsp stalls,
// set by the single result register, which reloads in the same cycle it is
// drained. Prefix and modifier words, releases and unmapped keys update
// state and produce no output word. Write code_set only while idle.
module ps2_scancode_to_text_decoder_core (
   input  logic                          clock,
   input  logic                          reset,
   ps2d_req_if.sink                      req,
   ps2d_rsp_if.source                    rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ps2d_pkg::PADDR_W-1:0]  paddr,
   input  logic [ps2d_pkg::PDATA_W-1:0]  pwdata,
   output logic [ps2d_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready
);

   // configuration
   logic [ps2d_pkg::CSET_W-1:0] code_set_ff;
   logic [ps2d_pkg::CSET_W-1:0] code_set_in;

   // decoder state and result register
   ps2d_pkg::mod_state_type     state_ff;
   ps2d_pkg::mod_state_type     state_in;
   ps2d_pkg::mod_state_type     dec_state;
   logic                        dec_emit;
   logic [ps2d_pkg::CHAR_W-1:0] dec_char;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [ps2d_pkg::CHAR_W-1:0] char_ff;
   logic [ps2d_pkg::CHAR_W-1:0] char_in;
   ps2d_pkg::mod_state_type     flags_ff;
   ps2d_pkg::mod_state_type     flags_in;

   logic                        req_fire;
   logic                        csr_wr;
   logic                        reg_sel;

   // register index is the word address; bit 2 of the byte address
   assign reg_sel = paddr[2];
   assign csr_wr  = psel && penable && pwrite && (reg_sel == ps2d_pkg::REG_CODE_SET);
   assign pready  = 1'b1;

   always_comb begin
      prdata = '0;
      if (reg_sel == ps2d_pkg::REG_CODE_SET) begin
         prdata = {{(ps2d_pkg::PDATA_W - ps2d_pkg::CSET_W){1'b0}}, code_set_ff};
      end
   end

   assign code_set_in = csr_wr ? pwdata[ps2d_pkg::CSET_W-1:0] : code_set_ff;

   // accept whenever the result register is empty or drains this cycle
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;

   ps2d_decode u_decode (
      .scan_byte (req.scan_byte),
      .code_set  (code_set_ff),
      .cur_state (state_ff),
      .nxt_state (dec_state),
      .emit      (dec_emit),
      .char_byte (dec_char)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      flags_in     = flags_ff;
      // drop the word once taken
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      // advance state on every accepted word; load a result only when it maps
      if (req_fire) begin
         state_in = dec_state;
         if (dec_emit) begin
            rsp_valid_in = 1'b1;
            char_in      = dec_char;
            flags_in     = dec_state;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_set_ff  <= '0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         code_set_ff  <= code_set_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds without reset
   always_ff @(posedge clock) begin
      char_ff  <= char_in;
      flags_ff <= flags_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.char_byte  = char_ff;
   assign rsp.shift_down = flags_ff.shift;
   assign rsp.ctrl_down  = flags_ff.ctrl;
   assign rsp.alt_down   = flags_ff.alt;
   assign rsp.caps_lock  = flags_ff.caps;

endmodule

// ===== tb/ps2d_text_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2d_text_check
// Watches the scancode, character and register ports of the decoder, keeps
// its own keyboard state, and compares each character word with the next
// one it expects.
// ----------------------------------------------------------------------------
module ps2d_text_check
   import ps2d_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   ps2d_req_if                 req,
   ps2d_rsp_if                 rsp,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic                pready,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [PDATA_W-1:0]  pwdata,
   output int unsigned         error_count,
   output int unsigned         words_due
);

   localparam logic [PADDR_W-1:0] CODE_SET_ADDR = PADDR_W'(4 * REG_CODE_SET);

   // set 2 code to set 1 key code, entry 0 first
   localparam logic [0:127][7:0] SET2_XLATE = {
      128'h003B_003F_3D3B_3C58_0044_4240_3E0F_2900,
      128'h0038_2A00_1D10_0200_0000_2C1F_1E11_0300,
      128'h002E_2D20_1205_0400_0039_2F21_1413_0600,
      128'h0031_3023_2215_0700_0000_3224_1608_0900,
      128'h0033_2517_180B_0A00_0034_3526_2719_0C00,
      128'h0000_2800_1A0D_0000_3A36_1C1B_002B_0000,
      128'h0000_0000_0000_0E00_004F_004B_4700_0000,
      128'h5253_504C_4E48_0145_574E_4D4A_3749_4600
   };

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              shift;
      logic              ctrl;
      logic              alt;
      logic              caps;
   } char_word_type;

   logic [CSET_W-1:0] cur_set;
   mod_state_type     kb;
   char_word_type     due_chars[$];
   int unsigned       errs;

   // plain and shifted character of a set 1 key, plain in the upper byte
   function automatic logic [15:0] us_key_pair(input logic [6:0] key);
      logic [15:0] p;
      p = '0;
      case (key)
         7'h02: p = "1!";  7'h03: p = "2@";  7'h04: p = "3#";  7'h05: p = "4$";
         7'h06: p = "5%";  7'h07: p = "6^";  7'h08: p = "7&";  7'h09: p = "8*";
         7'h0A: p = "9(";  7'h0B: p = "0)";  7'h0C: p = "-_";  7'h0D: p = "=+";
         7'h0E: p = "\010\010";            7'h0F: p = "\t\t";
         7'h10: p = "qQ";  7'h11: p = "wW";  7'h12: p = "eE";  7'h13: p = "rR";
         7'h14: p = "tT";  7'h15: p = "yY";  7'h16: p = "uU";  7'h17: p = "iI";
         7'h18: p = "oO";  7'h19: p = "pP";  7'h1A: p = "[{";  7'h1B: p = "]}";
         7'h1C: p = "\n\n";                7'h1E: p = "aA";  7'h1F: p = "sS";
         7'h20: p = "dD";  7'h21: p = "fF";  7'h22: p = "gG";  7'h23: p = "hH";
         7'h24: p = "jJ";  7'h25: p = "kK";  7'h26: p = "lL";  7'h27: p = ";:";
         7'h28: p = "'\""; 7'h29: p = "\140~"; 7'h2B: p = "\\|"; 7'h2C: p = "zZ";
         7'h2D: p = "xX";  7'h2E: p = "cC";  7'h2F: p = "vV";  7'h30: p = "bB";
         7'h31: p = "nN";  7'h32: p = "mM";  7'h33: p = ",<";  7'h34: p = ".>";
         7'h35: p = "/?";  7'h39: p = "  ";
         default: p = '0;
      endcase
      return p;
   endfunction

   // advance the keyboard state by one scancode; 1 when a character is due
   function automatic bit decode_scan_byte(input logic [SCAN_W-1:0] b,
                                           output char_word_type w);
      logic [SCAN_W-1:0] key;
      logic              rel;
      logic [15:0]       pair;
      key = b;
      rel = 1'b0;
      w   = '0;
      if (cur_set == CSET_TWO) begin
         if (b == PREFIX_RELEASE) begin
            kb.release_pending = 1'b1;
            return 1'b0;
         end
         rel = kb.release_pending || b[7];
         key = (kb.release_pending && b[7]) ? '0 : SET2_XLATE[b[6:0]];
         kb.release_pending = 1'b0;
      end else if (cur_set == CSET_ONE) begin
         rel = b[7];
         key = {1'b0, b[6:0]};
      end
      if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
         kb.shift = !rel;
         return 1'b0;
      end
      if (key == KEY_CTRL) begin
         kb.ctrl = !rel;
         return 1'b0;
      end
      if (key == KEY_ALT) begin
         kb.alt = !rel;
         return 1'b0;
      end
      if (key == KEY_CAPS && !rel) begin
         kb.caps = !kb.caps;
         return 1'b0;
      end
      if (rel || key[7])
         return 1'b0;
      pair = us_key_pair(key[6:0]);
      w.ch = (kb.shift ^ kb.caps) ? pair[6:0] : pair[14:8];
      if (w.ch == '0)
         return 1'b0;
      w.shift = kb.shift;
      w.ctrl  = kb.ctrl;
      w.alt   = kb.alt;
      w.caps  = kb.caps;
      return 1'b1;
   endfunction

   task automatic check_field(input string what, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, what, want, got);
         errs++;
      end
   endtask

   always @(posedge clock) begin : watch
      char_word_type got;
      char_word_type want;
      if (reset) begin
         cur_set = '0;
         kb      = '0;
         errs    = 0;
         due_chars.delete();
      end else begin
         // results first: a word leaving now belongs to an earlier scancode
         if (rsp.valid && rsp.ready) begin
            got = {rsp.char_byte, rsp.shift_down, rsp.ctrl_down, rsp.alt_down,
                   rsp.caps_lock};
            if (due_chars.size() == 0) begin
               $display("%0t: unexpected char word expected none actual %h", $time, got);
               errs++;
            end else begin
               want = due_chars.pop_front();
               check_field("char_byte", 8'(want.ch), 8'(got.ch));
               check_field("shift_down", 8'(want.shift), 8'(got.shift));
               check_field("ctrl_down", 8'(want.ctrl), 8'(got.ctrl));
               check_field("alt_down", 8'(want.alt), 8'(got.alt));
               check_field("caps_lock", 8'(want.caps), 8'(got.caps));
            end
         end
         if (psel && penable && pwrite && pready && paddr == CODE_SET_ADDR)
            cur_set = pwdata[CSET_W-1:0];
         if (req.valid && req.ready) begin
            if (decode_scan_byte(req.scan_byte, want))
               due_chars.push_back(want);
         end
      end
      error_count <= errs;
      words_due   <= due_chars.size();
   end

endmodule

// ===== tb/ps2_scancode_to_text_decoder_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_scancode_to_text_decoder_core_test
// Drives scancode words through every code set: a directed set 2 typing run,
// then random keystrokes, modifier chords and stray bytes, with random gaps
// and a long output hold-off. A separate checker predicts each character.
// ----------------------------------------------------------------------------
module ps2_scancode_to_text_decoder_core_test;
   import ps2d_pkg::*;

   localparam logic [PADDR_W-1:0] CODE_SET_ADDR = PADDR_W'(4 * REG_CODE_SET);
   // raw modes: the byte itself is the key code
   localparam logic [CSET_W-1:0]  CSET_RAW_LO   = 2'd0;
   localparam logic [CSET_W-1:0]  CSET_RAW_HI   = 2'd3;
   localparam logic [SCAN_W-1:0]  RELEASE_BIT   = 8'h80;

   // set 2 codes of left shift, right shift, ctrl, alt and caps lock
   localparam logic [0:4][SCAN_W-1:0] SET2_MODIFIERS = {8'h12, 8'h59, 8'h14, 8'h11, 8'h58};
   localparam logic [0:4][SCAN_W-1:0] SET1_MODIFIERS = {KEY_LSHIFT, KEY_RSHIFT, KEY_CTRL,
                                                        KEY_ALT, KEY_CAPS};

   // set 2 typing: a, shift+a, caps chords, ctrl/alt, short release, prefix
   // before a high byte; ends on a bare prefix left pending for later phases
   localparam int DIRECTED_LEN = 22;
   localparam logic [0:DIRECTED_LEN-1][SCAN_W-1:0] DIRECTED_SET2 = {
      8'h1C, 8'h12, 8'h1C, 8'hF0, 8'h12, 8'h58, 8'hF0, 8'h58, 8'h1C, 8'h59, 8'h1C,
      8'hF0, 8'h59, 8'h14, 8'h11, 8'h16, 8'h94, 8'hF0, 8'hFF, 8'h91, 8'h58, 8'hF0
   };
   // set 1 field extremes plus caps press and its release
   localparam logic [0:5][SCAN_W-1:0] DIRECTED_SET1 = {8'h00, 8'h7F, 8'h80, 8'hFF,
                                                       8'h3A, 8'hBA};

   // random phases: code set of each phase
   localparam int PHASES = 8;
   localparam logic [0:PHASES-1][CSET_W-1:0] PHASE_SET = {
      CSET_ONE, CSET_RAW_LO, CSET_RAW_HI, CSET_TWO, CSET_ONE, CSET_TWO, CSET_RAW_HI,
      CSET_TWO
   };
   localparam int HOLD_PHASE  = 3;
   localparam int HOLD_CYCLES = 400;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [PDATA_W-1:0]  pwdata = '0;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   int unsigned         error_count;
   int unsigned         words_due;
   int unsigned         words_sent = 0;
   int unsigned         gap_pct = 0;      // chance of a sender gap before a word
   bit                  rsp_stalls = 1'b0;
   bit                  hold_request = 1'b0;

   ps2d_req_if req_bus ();
   ps2d_rsp_if rsp_bus ();

   ps2_scancode_to_text_decoder_core uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   ps2d_text_check char_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .error_count (error_count),
      .words_due   (words_due)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Offer one scancode word and hold it until the block takes it. A random
   // gap may come first; valid is left high afterwards so back-to-back words
   // stream without a bubble.
   task automatic send_scan(input logic [SCAN_W-1:0] b);
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.scan_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
   endtask

   // Register write: setup, then access until pready.
   task automatic csr_write(input logic [CSET_W-1:0] v);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CODE_SET_ADDR;
      pwdata  <= PDATA_W'(v);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Drop valid, wait for every expected word, then wait out the latency of
   // words that produce nothing.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One keystroke in the given set: a press, a release (prefixed in set 2,
   // bit 7 otherwise), a set 2 short release, or a stray byte / lone prefix.
   // A fifth of the keys are modifiers so the chords keep changing.
   task automatic send_stroke(input logic [CSET_W-1:0] mode);
      int unsigned       kind;
      logic [SCAN_W-1:0] k;
      kind = $urandom_range(0, 99);
      k    = SCAN_W'($urandom_range(0, 127));
      if ($urandom_range(0, 4) == 0)
         k = (mode == CSET_TWO) ? SET2_MODIFIERS[$urandom_range(0, 4)]
                                : SET1_MODIFIERS[$urandom_range(0, 4)];
      if (kind >= 92) begin
         send_scan($urandom_range(0, 1) ? PREFIX_RELEASE : SCAN_W'($urandom_range(0, 255)));
      end else if (mode == CSET_TWO) begin
         if (kind < 60) begin
            send_scan(k);
         end else if (kind < 85) begin
            send_scan(PREFIX_RELEASE);
            send_scan(k);
         end else begin
            send_scan(k | RELEASE_BIT);
         end
      end else if (kind < 65) begin
         send_scan(k);
      end else begin
         send_scan(k | RELEASE_BIT);
      end
   endtask

   // Result side: ready high by default, random stall bursts when enabled,
   // and one long hold-off on request so the block backs up into req.
   initial begin : drain
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (rsp_stalls && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int unsigned phase_start;
      int unsigned quota;
      req_bus.valid     <= 1'b0;
      req_bus.scan_byte <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed set 2 typing with light idling on both sides
      csr_write(CSET_TWO);
      gap_pct    = 20;
      rsp_stalls = 1'b1;
      for (int i = 0; i < DIRECTED_LEN; i++)
         send_scan(DIRECTED_SET2[i]);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         csr_write(PHASE_SET[p]);
         // last phase runs flat out; others pick a random idling level
         if (p == PHASES - 1) begin
            gap_pct    = 0;
            rsp_stalls = 1'b0;
         end else begin
            gap_pct    = $urandom_range(0, 2) * 15;
            rsp_stalls = 1'($urandom_range(0, 1));
         end
         if (p == HOLD_PHASE)
            hold_request = 1'b1;
         if (p == 0) begin
            for (int i = 0; i < 6; i++)
               send_scan(DIRECTED_SET1[i]);
         end
         quota       = (PHASE_SET[p] == CSET_TWO) ? 300 : 180;
         phase_start = words_sent;
         while (words_sent - phase_start < quota)
            send_stroke(PHASE_SET[p]);
         settle();
      end

      if (error_count == 0 && words_due == 0) begin
         $display("ps2_scancode_to_text_decoder_core_test: clean");
      end else begin
         $display("ps2_scancode_to_text_decoder_core_test: errors");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("ps2_scancode_to_text_decoder_core_test: errors");
      $finish;
   end

endmodule
